/* sv/tcjd_pkg.sv */
// Shared constants, field layouts and types of the two-class job dispatcher.
`default_nettype none

package tcjd_pkg;

    localparam int JOB_SLOTS    = 64;
    localparam int OWNER_SLOTS  = 16;
    localparam int COUNTER_BITS = 32;

    localparam int JOB_W  = $clog2(JOB_SLOTS);
    localparam int OWN_W  = $clog2(OWNER_SLOTS);
    localparam int CNT_W  = $clog2(JOB_SLOTS + 1);
    localparam int CTR_W  = COUNTER_BITS;
    localparam int MODE_W = 3;

    // Input item: tdata carries job_id, owner_id, job_hot, again from bit 0 up.
    localparam int IN_FIELDS_W = JOB_W + OWN_W + 2;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

    // Result item: all twelve fields packed in tdata.
    localparam int OUT_FIELDS_W = 1 + 1 + JOB_W + CNT_W + 1 + 4 * CNT_W + 3 * CTR_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [MODE_W-1:0] MODE_SUBMIT   = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_DISPATCH = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_FINISH   = MODE_W'(2);
    localparam logic [MODE_W-1:0] MODE_STOP     = MODE_W'(3);
    localparam logic [MODE_W-1:0] MODE_INIT     = MODE_W'(4);

    typedef enum logic [2:0] {
        ALU_PASS,
        ALU_INC,
        ALU_DEC_SAT,
        ALU_CLR,
        ALU_MAX
    } t_alu_op;

    typedef struct packed {
        logic             push;
        logic             pop;
        logic [JOB_W-1:0] push_job;
    } t_fifo_ctl;

    typedef struct packed {
        logic [OWN_W-1:0] owner;
        logic             hot;
    } t_job_rec;

    typedef struct packed {
        logic             wr_en;
        logic [JOB_W-1:0] wr_addr;
        t_job_rec         wr_rec;
        logic [JOB_W-1:0] rd_addr;
    } t_tab_ctl;

    // Counter operations that one item leaves for the sequencer.
    typedef struct packed {
        t_alu_op pend;
        t_alu_op queued;
        t_alu_op active;
        t_alu_op subm;
        t_alu_op compl;
        t_alu_op disp;
    } t_plan;

endpackage

`default_nettype wire

/* sv/tcjd_alu.sv */
// Shared counter unit: pass-through, increment, saturating decrement, clear and maximum.
`default_nettype none

module tcjd_alu
    import tcjd_pkg::*;
(
    input  wire t_alu_op           i_op,
    input  wire logic [CTR_W-1:0]  i_a,
    input  wire logic [CTR_W-1:0]  i_b,
    output logic      [CTR_W-1:0]  o_y
);

    always_comb begin
        unique case (i_op)
            ALU_PASS:    o_y = i_a;
            ALU_INC:     o_y = i_a + CTR_W'(1);
            ALU_DEC_SAT: o_y = (i_a == '0) ? '0 : i_a - CTR_W'(1);
            ALU_CLR:     o_y = '0;
            ALU_MAX:     o_y = (i_a > i_b) ? i_a : i_b;
            default:     o_y = i_a;
        endcase
    end

endmodule

`default_nettype wire

/* sv/tcjd_fifo.sv */
// Circular job queue for one class, with a registered read of the head entry.
`default_nettype none

module tcjd_fifo
    import tcjd_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire t_fifo_ctl         i_ctl,
    output logic [JOB_W-1:0]       o_head_job,
    output logic [CNT_W-1:0]       o_count
);

    logic [JOB_W-1:0] r_mem [JOB_SLOTS];
    logic [JOB_W-1:0] r_head;
    logic [CNT_W-1:0] r_count;
    logic [JOB_W-1:0] r_head_job;
    logic [JOB_W:0]   tail_sum;
    logic [JOB_W-1:0] tail;

    always_comb begin
        tail_sum = {1'b0, r_head} + (JOB_W + 1)'(r_count);
        if (tail_sum >= (JOB_W + 1)'(JOB_SLOTS)) begin
            tail = JOB_W'(tail_sum - (JOB_W + 1)'(JOB_SLOTS));
        end else begin
            tail = tail_sum[JOB_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            if (i_ctl.pop) begin
                r_head <= (r_head == JOB_W'(JOB_SLOTS - 1)) ? '0 : r_head + JOB_W'(1);
            end
            r_count <= r_count + CNT_W'(i_ctl.push) - CNT_W'(i_ctl.pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[tail] <= i_ctl.push_job;
        end
        r_head_job <= r_mem[r_head];
    end

    assign o_head_job = r_head_job;
    assign o_count    = r_count;

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.pop |-> (r_count != '0))
        else $error("job queue popped while empty");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.push |-> (r_count < CNT_W'(JOB_SLOTS)))
        else $error("job queue pushed while full");

endmodule

`default_nettype wire

/* sv/tcjd_job_tab.sv */
// Per-job record of owner and class, written on submit, with a registered read.
`default_nettype none

module tcjd_job_tab
    import tcjd_pkg::*;
(
    input  wire           i_clk,
    input  wire t_tab_ctl i_ctl,
    output t_job_rec      o_rec
);

    t_job_rec r_mem [JOB_SLOTS];
    t_job_rec r_rd_rec;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_ctl.wr_rec;
        end
        r_rd_rec <= r_mem[i_ctl.rd_addr];
    end

    assign o_rec = r_rd_rec;

endmodule

`default_nettype wire

/* sv/two_class_job_dispatcher.sv */
// Top level of the two-class job dispatcher: sequencer, job state and result register.
// The block is a strict-priority work queue with a hot and a normal job class.
// Requests arrive as items on the slave stream: tuser carries the mode (submit,
// dispatch request, finish step, stop owner, init owner) and tdata the job,
// owner, class and again fields. Every request gives exactly one result item on
// the master stream, carrying the decision flags, the granted job, the
// addressed owner's pending count, the job's busy mark and all statistics.
// One item is handled at a time. After acceptance the sequencer does the flag
// checks and queue access in S_LOOK and the job table read in S_TABLE, and then
// steps through S_CALC, in which a single shared counter unit updates, one per
// cycle, the pending count, queued count and peak, active count and peak, and the
// submitted, completed and dispatched counters. S_OUT then loads the result
// register, and the next item is accepted only after that load. The result waits
// in an output register; while the receiver stalls, the block finishes the next
// item up to the point of loading that register and holds there. A synchronous,
// active-low reset empties both queues, clears all busy, active and stopping
// marks, pending counts and statistics, and drops any result not yet taken; the
// block takes items from the first cycle after reset.
`default_nettype none

module two_class_job_dispatcher
    import tcjd_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_s_tvalid,
    output logic                     o_s_tready,
    // job_id, owner_id, job_hot, again (from bit 0 up), zero padded
    input  wire  [IN_TDATA_W-1:0]    i_s_tdata,
    // mode
    input  wire  [MODE_W-1:0]        i_s_tuser,
    output logic                     o_m_tvalid,
    input  wire                      i_m_tready,
    // accepted, grant_valid, grant_job, owner_pending, job_busy, queued_count,
    // queued_max, active_count, active_peak, submitted_count, completed_count,
    // dispatch_count (from bit 0 up), zero padded
    output logic [OUT_TDATA_W-1:0]   o_m_tdata
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOOK  = 3'd1;
    localparam logic [2:0] S_TABLE = 3'd2;
    localparam logic [2:0] S_CALC  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    localparam logic [2:0] STEP_PEND   = 3'd0;
    localparam logic [2:0] STEP_QUEUED = 3'd1;
    localparam logic [2:0] STEP_QPEAK  = 3'd2;
    localparam logic [2:0] STEP_ACTIVE = 3'd3;
    localparam logic [2:0] STEP_APEAK  = 3'd4;
    localparam logic [2:0] STEP_SUBM   = 3'd5;
    localparam logic [2:0] STEP_COMPL  = 3'd6;
    localparam logic [2:0] STEP_DISP   = 3'd7;

    localparam int PAD_W = OUT_TDATA_W - OUT_FIELDS_W;

    logic [2:0]              r_state;
    logic [2:0]              n_state;
    logic [2:0]              r_step;

    // Latched request.
    logic [MODE_W-1:0]       r_mode;
    logic [JOB_W-1:0]        r_job;
    logic [OWN_W-1:0]        r_own;
    logic                    r_hot;
    logic                    r_again;

    // Job and owner state.
    logic [JOB_SLOTS-1:0]    r_busy;
    logic [JOB_SLOTS-1:0]    r_active;
    logic [OWNER_SLOTS-1:0]  r_stop;
    logic [CNT_W-1:0]        r_pend [OWNER_SLOTS];

    // Statistics.
    logic [CNT_W-1:0]        r_queued;
    logic [CNT_W-1:0]        r_qpeak;
    logic [CNT_W-1:0]        r_act_cnt;
    logic [CNT_W-1:0]        r_apeak;
    logic [CTR_W-1:0]        r_subm;
    logic [CTR_W-1:0]        r_compl;
    logic [CTR_W-1:0]        r_disp;

    // Per-item decisions.
    t_plan                   r_plan;
    logic [OWN_W-1:0]        r_powner;
    logic                    r_pend_rep;
    logic                    r_from_tab;
    logic                    r_fin_act;
    logic                    r_acc;
    logic                    r_gv;
    logic [JOB_W-1:0]        r_grant;
    logic [JOB_W-1:0]        r_jaddr;
    logic                    r_jb_rep;
    logic [CNT_W-1:0]        r_pend_out;

    logic                    r_m_valid;
    logic [OUT_TDATA_W-1:0]  r_m_data;
    logic [OUT_TDATA_W-1:0]  n_m_data;

    t_fifo_ctl               hot_ctl;
    t_fifo_ctl               nrm_ctl;
    logic [JOB_W-1:0]        hot_head;
    logic [JOB_W-1:0]        nrm_head;
    logic [CNT_W-1:0]        hot_cnt;
    logic [CNT_W-1:0]        nrm_cnt;
    t_tab_ctl                tab_ctl;
    t_job_rec                tab_rec;

    t_alu_op                 alu_op;
    logic [CTR_W-1:0]        alu_a;
    logic [CTR_W-1:0]        alu_b;
    logic [CTR_W-1:0]        alu_y;

    logic                    sub_ok;
    logic                    disp_hot;
    logic                    disp_any;
    logic [JOB_W-1:0]        grant_head;
    logic                    requeue;
    logic                    out_free;

    tcjd_fifo u_hot_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (hot_ctl),
        .o_head_job (hot_head),
        .o_count    (hot_cnt)
    );

    tcjd_fifo u_nrm_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (nrm_ctl),
        .o_head_job (nrm_head),
        .o_count    (nrm_cnt)
    );

    tcjd_job_tab u_job_tab (
        .i_clk (i_clk),
        .i_ctl (tab_ctl),
        .o_rec (tab_rec)
    );

    tcjd_alu u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign out_free   = !r_m_valid || i_m_tready;

    // Admission needs a free job and an owner that is open.
    assign sub_ok     = !r_stop[r_own] && !r_busy[r_job];
    assign disp_hot   = (hot_cnt != '0);
    assign disp_any   = disp_hot || (nrm_cnt != '0);
    assign grant_head = disp_hot ? hot_head : nrm_head;
    // A finished quantum with again set goes back to its queue unless its owner is stopping.
    assign requeue    = r_fin_act && r_again && !r_stop[tab_rec.owner];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_s_tvalid) n_state = S_LOOK;
            S_LOOK:  n_state = S_TABLE;
            S_TABLE: n_state = S_CALC;
            S_CALC:  if (r_step == STEP_DISP) n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Queue pushes and pops, and job table access.
    always_comb begin
        hot_ctl = '0;
        nrm_ctl = '0;
        tab_ctl = '0;
        tab_ctl.wr_addr     = r_job;
        tab_ctl.wr_rec.owner = r_own;
        tab_ctl.wr_rec.hot   = r_hot;
        tab_ctl.rd_addr = (r_mode == MODE_DISPATCH) ? grant_head : r_job;
        hot_ctl.push_job = r_job;
        nrm_ctl.push_job = r_job;
        if (r_state == S_LOOK) begin
            if (r_mode == MODE_SUBMIT && sub_ok) begin
                tab_ctl.wr_en = 1'b1;
                hot_ctl.push  = r_hot;
                nrm_ctl.push  = !r_hot;
            end
            if (r_mode == MODE_DISPATCH && disp_any) begin
                hot_ctl.pop = disp_hot;
                nrm_ctl.pop = !disp_hot;
            end
        end
        if (r_state == S_TABLE && requeue) begin
            hot_ctl.push = tab_rec.hot;
            nrm_ctl.push = !tab_rec.hot;
        end
    end

    // Operand selection for the shared counter unit, one counter per step.
    always_comb begin
        alu_op = ALU_PASS;
        alu_a  = '0;
        alu_b  = '0;
        unique case (r_step)
            STEP_PEND: begin
                alu_op = r_plan.pend;
                alu_a  = CTR_W'(r_pend[r_powner]);
            end
            STEP_QUEUED: begin
                alu_op = r_plan.queued;
                alu_a  = CTR_W'(r_queued);
            end
            STEP_QPEAK: begin
                alu_op = ALU_MAX;
                alu_a  = CTR_W'(r_queued);
                alu_b  = CTR_W'(r_qpeak);
            end
            STEP_ACTIVE: begin
                alu_op = r_plan.active;
                alu_a  = CTR_W'(r_act_cnt);
            end
            STEP_APEAK: begin
                alu_op = ALU_MAX;
                alu_a  = CTR_W'(r_act_cnt);
                alu_b  = CTR_W'(r_apeak);
            end
            STEP_SUBM: begin
                alu_op = r_plan.subm;
                alu_a  = r_subm;
            end
            STEP_COMPL: begin
                alu_op = r_plan.compl;
                alu_a  = r_compl;
            end
            STEP_DISP: begin
                alu_op = r_plan.disp;
                alu_a  = r_disp;
            end
            default: begin
                alu_op = ALU_PASS;
            end
        endcase
    end

    always_comb begin
        n_m_data = {
            {PAD_W{1'b0}},
            r_disp,
            r_compl,
            r_subm,
            r_apeak,
            r_act_cnt,
            r_qpeak,
            r_queued,
            r_jb_rep ? r_busy[r_jaddr] : 1'b0,
            r_pend_out,
            r_grant,
            r_gv,
            r_acc
        };
    end

    // Request fields and the result word need no reset.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_s_tvalid) begin
            r_mode  <= i_s_tuser;
            r_job   <= i_s_tdata[JOB_W-1:0];
            r_own   <= i_s_tdata[JOB_W +: OWN_W];
            r_hot   <= i_s_tdata[JOB_W + OWN_W];
            r_again <= i_s_tdata[JOB_W + OWN_W + 1];
        end
        if (r_state == S_OUT && out_free) begin
            r_m_data <= n_m_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= STEP_PEND;
            r_busy     <= '0;
            r_active   <= '0;
            r_stop     <= '0;
            for (int i = 0; i < OWNER_SLOTS; i++) begin
                r_pend[i] <= '0;
            end
            r_queued   <= '0;
            r_qpeak    <= '0;
            r_act_cnt  <= '0;
            r_apeak    <= '0;
            r_subm     <= '0;
            r_compl    <= '0;
            r_disp     <= '0;
            r_plan     <= '{ALU_PASS, ALU_PASS, ALU_PASS, ALU_PASS, ALU_PASS, ALU_PASS};
            r_powner   <= '0;
            r_pend_rep <= 1'b0;
            r_from_tab <= 1'b0;
            r_fin_act  <= 1'b0;
            r_acc      <= 1'b0;
            r_gv       <= 1'b0;
            r_grant    <= '0;
            r_jaddr    <= '0;
            r_jb_rep   <= 1'b0;
            r_pend_out <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            // The result register fills when an item is done and empties when
            // the receiver takes it.
            if (r_state == S_OUT && out_free) begin
                r_m_valid <= 1'b1;
            end else if (o_m_tvalid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_plan     <= '{ALU_PASS, ALU_PASS, ALU_PASS,
                                        ALU_PASS, ALU_PASS, ALU_PASS};
                        r_powner   <= i_s_tdata[JOB_W +: OWN_W];
                        r_pend_rep <= 1'b0;
                        r_from_tab <= 1'b0;
                        r_fin_act  <= 1'b0;
                        r_acc      <= 1'b0;
                        r_gv       <= 1'b0;
                        r_grant    <= '0;
                        r_jaddr    <= i_s_tdata[JOB_W-1:0];
                        r_jb_rep   <= 1'b0;
                        r_step     <= STEP_PEND;
                    end
                end
                S_LOOK: begin
                    unique case (r_mode)
                        MODE_SUBMIT: begin
                            r_pend_rep <= 1'b1;
                            r_jb_rep   <= 1'b1;
                            if (sub_ok) begin
                                r_busy[r_job] <= 1'b1;
                                r_acc         <= 1'b1;
                                r_plan.pend   <= ALU_INC;
                                r_plan.queued <= ALU_INC;
                                r_plan.subm   <= ALU_INC;
                            end
                        end
                        MODE_DISPATCH: begin
                            if (disp_any) begin
                                r_gv                 <= 1'b1;
                                r_grant              <= grant_head;
                                r_jaddr              <= grant_head;
                                r_jb_rep             <= 1'b1;
                                r_pend_rep           <= 1'b1;
                                r_from_tab           <= 1'b1;
                                r_active[grant_head] <= 1'b1;
                                r_plan.queued        <= ALU_DEC_SAT;
                                r_plan.active        <= ALU_INC;
                                r_plan.disp          <= ALU_INC;
                            end
                        end
                        MODE_FINISH: begin
                            // A finish for a job that is not running changes nothing.
                            r_jb_rep <= 1'b1;
                            if (r_active[r_job]) begin
                                r_fin_act       <= 1'b1;
                                r_from_tab      <= 1'b1;
                                r_pend_rep      <= 1'b1;
                                r_active[r_job] <= 1'b0;
                                r_plan.active   <= ALU_DEC_SAT;
                            end
                        end
                        MODE_STOP: begin
                            r_stop[r_own] <= 1'b1;
                            r_pend_rep    <= 1'b1;
                        end
                        MODE_INIT: begin
                            r_stop[r_own] <= 1'b0;
                            r_pend_rep    <= 1'b1;
                            r_plan.pend   <= ALU_CLR;
                        end
                        default: begin
                            r_pend_rep <= 1'b0;
                        end
                    endcase
                end
                S_TABLE: begin
                    if (r_from_tab) begin
                        r_powner <= tab_rec.owner;
                    end
                    if (r_fin_act) begin
                        if (requeue) begin
                            r_plan.queued <= ALU_INC;
                        end else begin
                            r_busy[r_job] <= 1'b0;
                            r_plan.compl  <= ALU_INC;
                            r_plan.pend   <= ALU_DEC_SAT;
                        end
                    end
                end
                S_CALC: begin
                    r_step <= r_step + 3'd1;
                    unique case (r_step)
                        STEP_PEND: begin
                            r_pend[r_powner] <= alu_y[CNT_W-1:0];
                            r_pend_out       <= r_pend_rep ? alu_y[CNT_W-1:0] : '0;
                        end
                        STEP_QUEUED: r_queued  <= alu_y[CNT_W-1:0];
                        STEP_QPEAK:  r_qpeak   <= alu_y[CNT_W-1:0];
                        STEP_ACTIVE: r_act_cnt <= alu_y[CNT_W-1:0];
                        STEP_APEAK:  r_apeak   <= alu_y[CNT_W-1:0];
                        STEP_SUBM:   r_subm    <= alu_y;
                        STEP_COMPL:  r_compl   <= alu_y;
                        STEP_DISP:   r_disp    <= alu_y;
                        default:     r_disp    <= r_disp;
                    endcase
                end
                S_OUT: begin
                    // The result register is loaded above once it is free.
                end
                default: begin
                    r_step <= STEP_PEND;
                end
            endcase
        end
    end

    a_queued_matches_fifos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_queued == hot_cnt + nrm_cnt))
        else $error("queued count differs from the queue fill levels");

    a_active_matches_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(r_active) == int'(r_act_cnt)))
        else $error("active count differs from the active job marks");

    a_peaks_cover_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_qpeak >= r_queued && r_apeak >= r_act_cnt))
        else $error("a peak value fell below its count");

endmodule

`default_nettype wire

/* tb/sv/two_class_job_dispatcher_tb.sv */
// Self-checking testbench for the two-class job dispatcher, with a scoreboard mirror of the block.
module two_class_job_dispatcher_tb;
    import tcjd_pkg::*;

    // Each side may idle between items, and the block takes one item at a time.
    // No cycle should pass this many times without any item moving on either side.
    localparam int WATCHDOG_LIMIT = 2000;
    // Quiet cycles after the last result.
    localparam int SETTLE_CYCLES  = 40;
    localparam int RANDOM_ITEMS   = 1500;
    // The closing stretch of the random part runs with both sides always ready.
    localparam int CALM_TAIL      = 200;

    // Result item fields, from the most significant down; the last one sits at bit 0.
    typedef struct packed {
        logic [CTR_W-1:0] dispatch_count;
        logic [CTR_W-1:0] completed_count;
        logic [CTR_W-1:0] submitted_count;
        logic [CNT_W-1:0] active_peak;
        logic [CNT_W-1:0] active_count;
        logic [CNT_W-1:0] queued_max;
        logic [CNT_W-1:0] queued_count;
        logic             job_busy;
        logic [CNT_W-1:0] owner_pending;
        logic [JOB_W-1:0] grant_job;
        logic             grant_valid;
        logic             accepted;
    } t_dispatch_result;

    // Mirror of the dispatcher state. It predicts the result of every accepted
    // request and checks the results in the order they leave the block.
    class dispatcher_mirror;
        bit               busy[JOB_SLOTS];
        bit               running[JOB_SLOTS];
        bit [OWN_W-1:0]   owner_of[JOB_SLOTS];
        bit               hot_of[JOB_SLOTS];
        bit [JOB_W-1:0]   hot_line[$];
        bit [JOB_W-1:0]   normal_line[$];
        int               pend[OWNER_SLOTS];
        bit               stopping[OWNER_SLOTS];
        int               queued, queued_hi, running_n, running_hi;
        bit [CTR_W-1:0]   submitted, completed, dispatched;
        t_dispatch_result awaited[$];
        int               errors;
        int               checked;
        int               grants_missed;
        int               requeues;

        function void enqueue(bit [JOB_W-1:0] j);
            if (hot_of[j]) begin
                hot_line.push_back(j);
            end else begin
                normal_line.push_back(j);
            end
            queued++;
            if (queued > queued_hi) begin
                queued_hi = queued;
            end
        endfunction

        // Work out the result of one accepted request and update the mirror.
        function void note_request(bit [MODE_W-1:0] mode, bit [JOB_W-1:0] job,
                                   bit [OWN_W-1:0] own, bit hot, bit again);
            t_dispatch_result r;
            bit [JOB_W-1:0]   g;
            bit [OWN_W-1:0]   o;
            r = '0;
            case (mode)
                MODE_SUBMIT: begin
                    if (!stopping[own] && !busy[job]) begin
                        busy[job]     = 1'b1;
                        owner_of[job] = own;
                        hot_of[job]   = hot;
                        pend[own]++;
                        enqueue(job);
                        submitted++;
                        r.accepted = 1'b1;
                    end
                    r.owner_pending = CNT_W'(pend[own]);
                    r.job_busy      = busy[job];
                end
                MODE_DISPATCH: begin
                    if (hot_line.size() != 0 || normal_line.size() != 0) begin
                        // The hot class always goes first.
                        if (hot_line.size() != 0) begin
                            g = hot_line.pop_front();
                        end else begin
                            g = normal_line.pop_front();
                        end
                        queued--;
                        running_n++;
                        if (running_n > running_hi) begin
                            running_hi = running_n;
                        end
                        dispatched++;
                        running[g]      = 1'b1;
                        r.grant_valid   = 1'b1;
                        r.grant_job     = g;
                        r.owner_pending = CNT_W'(pend[owner_of[g]]);
                        r.job_busy      = busy[g];
                    end else begin
                        grants_missed++;
                    end
                end
                MODE_FINISH: begin
                    // A finish of a job that is not running changes nothing.
                    if (running[job]) begin
                        o = owner_of[job];
                        running[job] = 1'b0;
                        if (running_n > 0) begin
                            running_n--;
                        end
                        if (again && !stopping[o]) begin
                            enqueue(job);
                            requeues++;
                        end else begin
                            completed++;
                            busy[job] = 1'b0;
                            // An owner re-initialized under busy jobs stays at zero.
                            if (pend[o] > 0) begin
                                pend[o]--;
                            end
                        end
                        r.owner_pending = CNT_W'(pend[o]);
                    end
                    r.job_busy = busy[job];
                end
                MODE_STOP: begin
                    stopping[own]   = 1'b1;
                    r.owner_pending = CNT_W'(pend[own]);
                end
                MODE_INIT: begin
                    pend[own]       = 0;
                    stopping[own]   = 1'b0;
                    r.owner_pending = '0;
                end
                default: begin
                end
            endcase
            r.queued_count    = CNT_W'(queued);
            r.queued_max      = CNT_W'(queued_hi);
            r.active_count    = CNT_W'(running_n);
            r.active_peak     = CNT_W'(running_hi);
            r.submitted_count = submitted;
            r.completed_count = completed;
            r.dispatch_count  = dispatched;
            awaited.push_back(r);
        endfunction

        function void compare(string name, logic [CTR_W-1:0] want, logic [CTR_W-1:0] got);
            if (got !== want) begin
                $display("%0t: result %0d, %s mismatch: expected %0d, actual %0d",
                         $time, checked, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] td);
            t_dispatch_result got;
            t_dispatch_result want;
            got = td[OUT_FIELDS_W-1:0];
            if (awaited.size() == 0) begin
                $display("%0t: result item with nothing awaited: expected none, actual %h",
                         $time, td);
                errors++;
                return;
            end
            want = awaited.pop_front();
            compare("accepted", CTR_W'(want.accepted), CTR_W'(got.accepted));
            compare("grant_valid", CTR_W'(want.grant_valid), CTR_W'(got.grant_valid));
            compare("grant_job", CTR_W'(want.grant_job), CTR_W'(got.grant_job));
            compare("owner_pending", CTR_W'(want.owner_pending), CTR_W'(got.owner_pending));
            compare("job_busy", CTR_W'(want.job_busy), CTR_W'(got.job_busy));
            compare("queued_count", CTR_W'(want.queued_count), CTR_W'(got.queued_count));
            compare("queued_max", CTR_W'(want.queued_max), CTR_W'(got.queued_max));
            compare("active_count", CTR_W'(want.active_count), CTR_W'(got.active_count));
            compare("active_peak", CTR_W'(want.active_peak), CTR_W'(got.active_peak));
            compare("submitted_count", want.submitted_count, got.submitted_count);
            compare("completed_count", want.completed_count, got.completed_count);
            compare("dispatch_count", want.dispatch_count, got.dispatch_count);
            checked++;
        endfunction

        // A random running job, or -1 when none runs.
        function int pick_running();
            int list[$];
            foreach (running[j]) begin
                if (running[j]) begin
                    list.push_back(j);
                end
            end
            if (list.size() == 0) begin
                return -1;
            end
            return list[$urandom_range(0, list.size() - 1)];
        endfunction

        // A random job that is not busy, or -1 when all are.
        function int pick_free();
            int list[$];
            foreach (busy[j]) begin
                if (!busy[j]) begin
                    list.push_back(j);
                end
            end
            if (list.size() == 0) begin
                return -1;
            end
            return list[$urandom_range(0, list.size() - 1)];
        endfunction
    endclass

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;
    logic [MODE_W-1:0]      i_s_tuser  = MODE_SUBMIT;
    logic                   i_m_tready = 1'b0;
    logic                   o_s_tready;
    logic                   o_m_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    dispatcher_mirror mirror;
    bit               idle_on    = 1'b1;
    int               stall_left = 0;
    int               quiet_cycles = 0;

    two_class_job_dispatcher dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offer one request, wait for it to be taken, and note it in the mirror.
    // The valid stays high after acceptance so that back-to-back items need no
    // second assignment in one step; a gap lowers it first.
    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [JOB_W-1:0] job,
                                input logic [OWN_W-1:0] own, input logic hot,
                                input logic again);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= IN_TDATA_W'({again, hot, own, job});
        do @(posedge i_clk); while (!o_s_tready);
        mirror.note_request(mode, job, own, hot, again);
    endtask

    // One random request. Most traffic submits, dispatches and finishes real jobs
    // so that the queues fill and drain; stops, inits and unused modes are mixed in.
    task automatic random_request();
        int             roll;
        int             pick;
        logic [JOB_W-1:0] job;
        logic [OWN_W-1:0] own;
        logic           hot;
        logic           again;
        roll  = $urandom_range(0, 99);
        job   = JOB_W'($urandom);
        own   = OWN_W'($urandom);
        hot   = 1'($urandom);
        again = 1'($urandom);
        if (roll < 35) begin
            pick = mirror.pick_free();
            if (pick >= 0 && $urandom_range(0, 4) != 0) begin
                job = JOB_W'(pick);
            end
            send_request(MODE_SUBMIT, job, own, hot, again);
        end else if (roll < 60) begin
            send_request(MODE_DISPATCH, job, own, hot, again);
        end else if (roll < 88) begin
            pick = mirror.pick_running();
            if (pick >= 0 && $urandom_range(0, 6) != 0) begin
                job = JOB_W'(pick);
            end
            send_request(MODE_FINISH, job, own, hot, again);
        end else if (roll < 92) begin
            send_request(MODE_STOP, job, own, hot, again);
        end else if (roll < 97) begin
            send_request(MODE_INIT, job, own, hot, again);
        end else begin
            send_request(MODE_W'(MODE_INIT + $urandom_range(1, 3)), job, own, hot, again);
        end
    endtask

    // Receiver: check every result taken, then choose the ready for the next cycle.
    // Stalls come in bursts, only while idling is on.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            mirror.check_result(o_m_tdata);
        end
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 9);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Watchdog: a run in which no item moves for too long has hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("** two_class_job_dispatcher: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        int k;
        mirror = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Two submits of different classes, then a repeated
        // submit of a busy job, which must be refused.
        send_request(MODE_SUBMIT, 6'd0, 4'd0, 1'b0, 1'b0);
        send_request(MODE_SUBMIT, 6'd63, 4'd15, 1'b1, 1'b1);
        send_request(MODE_SUBMIT, 6'd0, 4'd0, 1'b1, 1'b0);
        // The hot job is granted ahead of the older normal one, then the queue runs dry.
        send_request(MODE_DISPATCH, 6'd0, 4'd0, 1'b0, 1'b0);
        send_request(MODE_DISPATCH, 6'd63, 4'd15, 1'b1, 1'b1);
        send_request(MODE_DISPATCH, 6'd0, 4'd0, 1'b0, 1'b0);
        // Requeue of a running job, a completion, and a finish of an idle job.
        send_request(MODE_FINISH, 6'd63, 4'd0, 1'b0, 1'b1);
        send_request(MODE_FINISH, 6'd0, 4'd15, 1'b1, 1'b0);
        send_request(MODE_FINISH, 6'd5, 4'd7, 1'b0, 1'b1);
        // A stopped owner gets no requeue and no new submits.
        send_request(MODE_STOP, 6'd0, 4'd15, 1'b0, 1'b0);
        send_request(MODE_DISPATCH, 6'd0, 4'd0, 1'b0, 1'b0);
        send_request(MODE_FINISH, 6'd63, 4'd0, 1'b0, 1'b1);
        send_request(MODE_SUBMIT, 6'd1, 4'd15, 1'b1, 1'b0);
        send_request(MODE_INIT, 6'd63, 4'd15, 1'b1, 1'b1);
        send_request(MODE_SUBMIT, 6'd1, 4'd15, 1'b1, 1'b0);
        // Re-init of an owner with a busy job: its pending count stays at zero
        // when that job completes.
        send_request(MODE_SUBMIT, 6'd2, 4'd3, 1'b0, 1'b0);
        send_request(MODE_INIT, 6'd0, 4'd3, 1'b0, 1'b0);
        send_request(MODE_DISPATCH, 6'd0, 4'd0, 1'b0, 1'b0);
        send_request(MODE_DISPATCH, 6'd0, 4'd0, 1'b0, 1'b0);
        send_request(MODE_FINISH, 6'd2, 4'd0, 1'b0, 1'b0);
        send_request(MODE_FINISH, 6'd1, 4'd0, 1'b0, 1'b0);
        // Unused modes change nothing.
        for (k = 1; k <= 3; k++) begin
            send_request(MODE_W'(MODE_INIT + k), 6'd63, 4'd15, 1'b1, 1'b1);
        end

        // Random part, with one stretch in the middle and the tail free of idling.
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            idle_on = (k < RANDOM_ITEMS - CALM_TAIL) && !(k >= 600 && k < 800);
            random_request();
        end
        i_s_tvalid <= 1'b0;

        while (mirror.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Checked %0d results: %0d jobs submitted, %0d dispatched, %0d completed.",
                 mirror.checked, mirror.submitted, mirror.dispatched, mirror.completed);
        $display("Requeues %0d, empty dispatches %0d, queue peak %0d, active peak %0d.",
                 mirror.requeues, mirror.grants_missed, mirror.queued_hi, mirror.running_hi);
        if (mirror.errors == 0) begin
            $display("** two_class_job_dispatcher: PASSED **");
        end else begin
            $display("** two_class_job_dispatcher: FAILED **");
        end
        $finish;
    end

endmodule
